### rtl/mmc_pkg.sv
package mmc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RAW_W = 16;
    localparam int EXT_W = 17;
    localparam int OFS_W = 17;
    localparam int GAIN_W = 24;
    localparam int ANG_W = 40;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 24'd65536;
    localparam logic [GAIN_W-1:0] GAIN_NUM = 24'd7864320;

    typedef struct packed {
        logic track;
        logic clear;
        logic start;
    } lane_ctl_t;

    function automatic int val_width(input int sb);
        return (sb > RAW_W) ? EXT_W : sb;
    endfunction

    function automatic logic [EXT_W-1:0] sample_ext(input logic [RAW_W-1:0] raw, input int sb);
        logic [EXT_W-1:0] v;
        logic s;
        int k;
        k = (sb > RAW_W) ? RAW_W : sb;
        s = (sb > RAW_W) ? 1'b0 : raw[k-1];
        for (int i = 0; i < EXT_W; i++)
        begin
            v[i] = (i < k) ? raw[i] : s;
        end
        return v;
    endfunction

endpackage

### rtl/mmc_lane.sv
module mmc_lane #(
    parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  mmc_pkg::lane_ctl_t                        ctl,
    input  logic signed [mmc_pkg::val_width(SAMPLE_BITS)-1:0] sample,
    output logic signed [mmc_pkg::OFS_W-1:0]          offset,
    output logic [mmc_pkg::GAIN_W-1:0]                gain,
    output logic                                      busy
);
    import mmc_pkg::*;

    localparam int VAL_W = val_width(SAMPLE_BITS);
    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic signed [VAL_W-1:0] hi_reg, hi_next;
    logic signed [VAL_W-1:0] lo_reg, lo_next;
    logic signed [OFS_W-1:0] ofs_reg, ofs_next;
    logic [GAIN_W-1:0]       gain_reg, gain_next;
    logic [GAIN_W-1:0]       num_reg, num_next;
    logic [VAL_W-1:0]        den_reg, den_next;
    logic [VAL_W:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;

    logic signed [VAL_W:0]   diff;
    logic [VAL_W-1:0]        range;
    logic [VAL_W:0]          rem_sh;

    always_comb
    begin
        diff   = (VAL_W+1)'(hi_reg) - (VAL_W+1)'(lo_reg);
        range  = diff[VAL_W-1:0];
        rem_sh = {rem_reg[VAL_W-1:0], num_reg[GAIN_W-1]};

        hi_next   = hi_reg;
        lo_next   = lo_reg;
        ofs_next  = ofs_reg;
        gain_next = gain_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;

        if (ctl.clear)
        begin
            hi_next = '0;
            lo_next = '0;
        end
        else if (ctl.track)
        begin
            if (sample > hi_reg)
                hi_next = sample;
            if (sample < lo_reg)
                lo_next = sample;
        end

        if (ctl.start)
        begin
            ofs_next = OFS_W'(hi_reg) + OFS_W'(lo_reg);
            if (hi_reg <= lo_reg)
            begin
                gain_next = '0;
            end
            else
            begin
                // rounded quotient: (num + range/2) / range, never above 2^23
                num_next  = GAIN_NUM + GAIN_W'(range >> 1);
                den_next  = range;
                rem_next  = '0;
                cnt_next  = CNT_W'(GAIN_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                num_next = {num_reg[GAIN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                num_next = {num_reg[GAIN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                gain_next = num_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg   <= '0;
            lo_reg   <= '0;
            ofs_reg  <= '0;
            gain_reg <= GAIN_ONE;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            ofs_reg  <= ofs_next;
            gain_reg <= gain_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign offset = ofs_reg;
    assign gain   = gain_reg;
    assign busy   = busy_reg;

endmodule

### rtl/mag_minmax_calibration_core.sv
// Flow: an accepted request passes EXEC and POST for start/idle/off-attitude samples, and
// EXEC, ACC, CHK and POST for tracking samples (multiply, accumulate, turn check); the
// compute step waits in DIV on the bit-serial dividers in the three axis lanes running
// in parallel. A new request is taken only in IDLE, once the last result is loaded for output.
// Reset (rst_n, async low): idle, step 0, turn angle and extremes zero, offsets zero, gains 1.0.
module mag_minmax_calibration_core #(
    parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic signed [15:0]                raw_x,
    input  logic signed [15:0]                raw_y,
    input  logic signed [15:0]                raw_z,
    input  logic signed [31:0]                rate_x,
    input  logic signed [31:0]                rate_z,
    input  logic [15:0]                       dt_us,
    input  logic [1:0]                        attitude,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              cal_active,
    output logic [1:0]                        cal_step,
    output logic                              done_res,
    output logic signed [mmc_pkg::OFS_W-1:0]  offset_x2,
    output logic signed [mmc_pkg::OFS_W-1:0]  offset_y2,
    output logic signed [mmc_pkg::OFS_W-1:0]  offset_z2,
    output logic [mmc_pkg::GAIN_W-1:0]        gain_x,
    output logic [mmc_pkg::GAIN_W-1:0]        gain_y,
    output logic [mmc_pkg::GAIN_W-1:0]        gain_z
);
    import mmc_pkg::*;

    localparam int VAL_W = val_width(SAMPLE_BITS);
    localparam int PROD_W = 49;
    localparam int SUM_W = 50;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_POST = 3'd5;

    localparam logic [1:0] STEP_H = 2'd0;
    localparam logic [1:0] STEP_V = 2'd1;
    localparam logic [1:0] STEP_C = 2'd2;

    localparam logic [1:0] ATT_LEVEL = 2'd1;
    localparam logic [1:0] ATT_NOSE  = 2'd2;

    localparam logic ACT_START = 1'b1;

    localparam logic signed [SUM_W-1:0] ANG_MAX = SUM_W'(64'sd549755813887);
    localparam logic signed [SUM_W-1:0] ANG_MIN = SUM_W'(-64'sd549755813888);
    localparam logic signed [ANG_W-1:0] TURN_LIM = ANG_W'(64'sd411774832291);
    localparam logic signed [ANG_W-1:0] TURN_NEG = ANG_W'(-64'sd411774832291);

    logic [2:0]               state_reg, state_next;
    logic                     active_reg, active_next;
    logic [1:0]               step_reg, step_next;
    logic signed [ANG_W-1:0]  turn_reg, turn_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     done_reg, done_next;

    logic                     act_reg;
    logic signed [VAL_W-1:0]  x_reg, y_reg, z_reg;
    logic signed [31:0]       rate_reg;
    logic [15:0]              dt_reg;
    logic [1:0]               att_reg;

    logic                     ov_reg, ov_next;
    logic                     o_active_reg;
    logic [1:0]               o_step_reg;
    logic                     o_done_reg;
    logic signed [OFS_W-1:0]  o_ofs_reg [3];
    logic [GAIN_W-1:0]        o_gain_reg [3];

    logic [EXT_W-1:0]         ext_x, ext_y, ext_z;
    logic signed [SUM_W-1:0]  acc_sum;
    lane_ctl_t                ctl_xy, ctl_z;
    logic signed [OFS_W-1:0]  lane_ofs [3];
    logic [GAIN_W-1:0]        lane_gain [3];
    logic [2:0]               lane_busy;
    logic                     load_out;

    assign ext_x = sample_ext(raw_x, SAMPLE_BITS);
    assign ext_y = sample_ext(raw_y, SAMPLE_BITS);
    assign ext_z = sample_ext(raw_z, SAMPLE_BITS);

    assign in_ready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_POST) && (!ov_reg || out_ready);

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        step_next   = step_reg;
        turn_next   = turn_reg;
        prod_next   = prod_reg;
        done_next   = done_reg;
        ctl_xy      = '0;
        ctl_z       = '0;
        acc_sum     = SUM_W'(turn_reg) + SUM_W'(prod_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                done_next = 1'b0;
                prod_next = rate_reg * $signed({1'b0, dt_reg});
                state_next = S_POST;
                if (act_reg == ACT_START)
                begin
                    active_next  = 1'b1;
                    step_next    = STEP_H;
                    turn_next    = '0;
                    ctl_xy.clear = 1'b1;
                    ctl_z.clear  = 1'b1;
                end
                else if (active_reg)
                begin
                    case (step_reg)
                        STEP_H:
                        begin
                            ctl_xy.track = 1'b1;
                            if (att_reg != ATT_LEVEL)
                            begin
                                ctl_xy.clear = 1'b1;
                                turn_next    = '0;
                            end
                            else
                            begin
                                state_next = S_ACC;
                            end
                        end
                        STEP_V:
                        begin
                            ctl_z.track = 1'b1;
                            if (att_reg != ATT_NOSE)
                            begin
                                ctl_z.clear = 1'b1;
                                turn_next   = '0;
                            end
                            else
                            begin
                                state_next = S_ACC;
                            end
                        end
                        default:
                        begin
                            ctl_xy.start = 1'b1;
                            ctl_z.start  = 1'b1;
                            state_next   = S_DIV;
                        end
                    endcase
                end
            end
            S_ACC:
            begin
                if (acc_sum > ANG_MAX)
                    turn_next = ANG_W'(ANG_MAX);
                else if (acc_sum < ANG_MIN)
                    turn_next = ANG_W'(ANG_MIN);
                else
                    turn_next = ANG_W'(acc_sum);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if ((turn_reg > TURN_LIM) || (turn_reg < TURN_NEG))
                begin
                    step_next = (step_reg == STEP_H) ? STEP_V : STEP_C;
                    turn_next = '0;
                end
                state_next = S_POST;
            end
            S_DIV:
            begin
                if (lane_busy == '0)
                begin
                    step_next   = STEP_H;
                    active_next = 1'b0;
                    done_next   = 1'b1;
                    state_next  = S_POST;
                end
            end
            S_POST:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ov_next = ov_reg;
        if (load_out)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
            step_reg   <= STEP_H;
            turn_reg   <= '0;
            done_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            step_reg   <= step_next;
            turn_reg   <= turn_next;
            done_reg   <= done_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (in_valid && in_ready)
        begin
            act_reg  <= action;
            x_reg    <= ext_x[VAL_W-1:0];
            y_reg    <= ext_y[VAL_W-1:0];
            z_reg    <= ext_z[VAL_W-1:0];
            rate_reg <= (step_reg == STEP_H) ? rate_z : rate_x;
            dt_reg   <= dt_us;
            att_reg  <= attitude;
        end
        if (load_out)
        begin
            o_active_reg <= active_reg;
            o_step_reg   <= step_reg;
            o_done_reg   <= done_reg;
            for (int i = 0; i < 3; i++)
            begin
                o_ofs_reg[i]  <= lane_ofs[i];
                o_gain_reg[i] <= lane_gain[i];
            end
        end
    end

    mmc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_xy),
        .sample (x_reg),
        .offset (lane_ofs[0]),
        .gain   (lane_gain[0]),
        .busy   (lane_busy[0])
    );

    mmc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_xy),
        .sample (y_reg),
        .offset (lane_ofs[1]),
        .gain   (lane_gain[1]),
        .busy   (lane_busy[1])
    );

    mmc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_z),
        .sample (z_reg),
        .offset (lane_ofs[2]),
        .gain   (lane_gain[2]),
        .busy   (lane_busy[2])
    );

    assign out_valid  = ov_reg;
    assign cal_active = o_active_reg;
    assign cal_step   = o_step_reg;
    assign done_res   = o_done_reg;
    assign offset_x2  = o_ofs_reg[0];
    assign offset_y2  = o_ofs_reg[1];
    assign offset_z2  = o_ofs_reg[2];
    assign gain_x     = o_gain_reg[0];
    assign gain_y     = o_gain_reg[1];
    assign gain_z     = o_gain_reg[2];

`ifndef ASSERT_OFF
    a_idle_step0: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (step_reg == STEP_H))
        else $error("step nonzero while not active");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !cal_active)
        else $error("done result reports active calibration");

    a_post_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST) |-> (lane_busy == '0))
        else $error("result posted while a divider runs");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");
`endif

endmodule
